FILE: hdl/lafm_pkg.sv
package lafm_pkg;

    localparam int BUFFER_DEPTH = 4096;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int SAMPLE_W     = 16;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIX_ENABLE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_MIC_MUTE   = CFG_INDEX_W'(1);

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_MIX  = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

endpackage

FILE: hdl/loopback_audio_fifo_mixer_top.sv
// Loopback FIFO with saturating microphone mixer. Push beats (func 0) store one
// mono sample (sample_a, or the stereo average truncated toward zero) into a
// 4096-entry sample RAM, overwriting the oldest sample when full; they give no
// result. Mix beats (func 1) give one result: the mic sample (zero when muted)
// plus, when mixing is on and the FIFO holds data, the oldest sample saturated
// to 16 bits; that sample is popped on the beat with last_channel set. The block
// takes one beat per clock while in_stall is low; a mix result passes through
// the stage-1 register and the synchronous RAM read, both latched at the accepting
// edge, then the add, saturate and output register, which loads once the output
// can take it. Pointers and fill count live in flops and update at the accepting
// edge, so a mix right after a push into an empty FIFO reads the fresh entry.
// Configuration writes are always taken (cfg_ready is tied high); the data is a
// single bit and indexes beyond mic_mute are ignored.
module loopback_audio_fifo_mixer_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lafm_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic                                   cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   func,
    input  logic signed [lafm_pkg::SAMPLE_W-1:0]   sample_a,
    input  logic signed [lafm_pkg::SAMPLE_W-1:0]   sample_b,
    input  logic                                   stereo,
    input  logic                                   last_channel,
    input  logic                                   block_end,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [lafm_pkg::SAMPLE_W-1:0]   mixed_sample,
    output logic                                   loopback_added,
    output logic                                   block_end_out
);

    import lafm_pkg::*;

    typedef struct packed
    {
        logic                       valid;
        logic                       added;
        logic                       block_end;
        logic signed [SAMPLE_W-1:0] mic;
    } mix_stage_t;

    logic [SAMPLE_W-1:0] sample_mem [BUFFER_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    logic mix_enable_reg;
    logic mic_mute_reg;

    mix_stage_t s1_reg, s1_next;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] mixed_sample_reg;
    logic                       loopback_added_reg;
    logic                       block_end_out_reg;

    logic                       out_take;
    logic                       s1_move;
    logic                       accept;
    logic                       push;
    logic                       mix;
    logic                       fifo_full;
    logic                       fifo_empty;
    logic                       do_add;
    logic signed [SAMPLE_W:0]   pair_sum;
    logic signed [SAMPLE_W:0]   pair_adj;
    logic signed [SAMPLE_W:0]   avg_wide;
    logic [SAMPLE_W-1:0]        push_sample;
    logic signed [SAMPLE_W:0]   mix_sum;
    logic signed [SAMPLE_W-1:0] mix_sat;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // handshake
    assign out_take  = !out_valid_reg || !out_stall;
    assign s1_move   = s1_reg.valid && out_take;
    assign in_stall  = s1_reg.valid && !out_take;
    assign accept    = in_valid && !in_stall;
    assign push      = accept && (func == FUNC_PUSH);
    assign mix       = accept && (func == FUNC_MIX);
    assign cfg_ready = 1'b1;

    assign fifo_full  = (fill_reg == CNT_W'(BUFFER_DEPTH));
    assign fifo_empty = (fill_reg == '0);
    assign do_add     = mix_enable_reg && !fifo_empty;

    // stereo average, truncated toward zero
    assign pair_sum    = {sample_a[SAMPLE_W-1], sample_a} + {sample_b[SAMPLE_W-1], sample_b};
    assign pair_adj    = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
    assign avg_wide    = pair_adj >>> 1;
    assign push_sample = stereo ? avg_wide[SAMPLE_W-1:0] : sample_a;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = advance(wr_ptr_reg);
            if (fifo_full)
            begin
                rd_ptr_next = advance(rd_ptr_reg);
            end
            else
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        else if (mix && do_add && last_channel)
        begin
            rd_ptr_next = advance(rd_ptr_reg);
            fill_next   = fill_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        s1_next = s1_reg;
        if (mix)
        begin
            s1_next.valid     = 1'b1;
            s1_next.added     = do_add;
            s1_next.block_end = block_end;
            s1_next.mic       = mic_mute_reg ? '0 : sample_a;
        end
        else if (s1_move)
        begin
            s1_next.valid = 1'b0;
        end
    end

    // sample RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            sample_mem[wr_ptr_reg] <= push_sample;
        end
        if (mix)
        begin
            rd_data_reg <= sample_mem[rd_ptr_reg];
        end
    end

    // add and saturate
    always_comb
    begin
        mix_sum = {s1_reg.mic[SAMPLE_W-1], s1_reg.mic};
        if (s1_reg.added)
        begin
            mix_sum = mix_sum + {rd_data_reg[SAMPLE_W-1], rd_data_reg};
        end
        if (mix_sum[SAMPLE_W] != mix_sum[SAMPLE_W-1])
        begin
            mix_sat = mix_sum[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
        end
        else
        begin
            mix_sat = mix_sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            fill_reg       <= '0;
            mix_enable_reg <= 1'b0;
            mic_mute_reg   <= 1'b0;
            s1_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
            s1_reg     <= s1_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIX_ENABLE: mix_enable_reg <= cfg_data;
                    CFG_MIC_MUTE:   mic_mute_reg   <= cfg_data;
                    default:        ;
                endcase
            end
            if (out_take)
            begin
                out_valid_reg <= s1_reg.valid;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            mixed_sample_reg   <= mix_sat;
            loopback_added_reg <= s1_reg.added;
            block_end_out_reg  <= s1_reg.block_end;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mixed_sample   = mixed_sample_reg;
    assign loopback_added = loopback_added_reg;
    assign block_end_out  = block_end_out_reg;

endmodule

FILE: tb/loopback_audio_fifo_mixer_top_tb.sv
module loopback_audio_fifo_mixer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lafm_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = CFG_INDEX_W'(3);

    localparam int SETTLE_CYCLES    = 6;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 3000;

    typedef struct packed {
        logic                       func;
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic                       stereo;
        logic                       last;
        logic                       bend;
    } audio_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed;
        logic                       added;
        logic                       bend;
    } mix_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic                       cfg_data  = 1'b0;

    logic                       in_valid     = 1'b0;
    logic                       in_stall;
    logic                       func         = FUNC_PUSH;
    logic signed [SAMPLE_W-1:0] sample_a     = '0;
    logic signed [SAMPLE_W-1:0] sample_b     = '0;
    logic                       stereo       = 1'b0;
    logic                       last_channel = 1'b0;
    logic                       block_end    = 1'b0;

    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       loopback_added;
    logic                       block_end_out;

    // predictor state
    logic [SAMPLE_W-1:0] loop_mem [BUFFER_DEPTH];
    int                  rd_ptr;
    int                  wr_ptr;
    int                  fill;
    logic                mix_en_reg;
    logic                mute_reg;

    audio_beat_t beat_q[$];
    mix_result_t expected_mix_q[$];
    audio_beat_t cur_beat;

    int  err_count;
    int  send_gap;
    int  stall_left;
    int  hold_left;
    int  hold_req_cnt;
    int  hold_ack_cnt;
    int  idle_cycles;
    logic quiet = 1'b0;

    loopback_audio_fifo_mixer_top i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .sample_a       (sample_a),
        .sample_b       (sample_b),
        .stereo         (stereo),
        .last_channel   (last_channel),
        .block_end      (block_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mixed_sample   (mixed_sample),
        .loopback_added (loopback_added),
        .block_end_out  (block_end_out)
    );

    always #5 clk = ~clk;

    function automatic int next_ptr(input int p);
        return (p == BUFFER_DEPTH - 1) ? 0 : p + 1;
    endfunction

    // updates the fifo image and queues the result a mix beat should give
    function automatic void predict_mix_result(input audio_beat_t bt);
        int          sum;
        int          mic;
        mix_result_t res;
        if (bt.func == FUNC_PUSH)
        begin
            sum = bt.stereo ? (int'($signed(bt.a)) + int'($signed(bt.b))) / 2
                            : int'($signed(bt.a));
            if (fill >= BUFFER_DEPTH)
            begin
                rd_ptr = next_ptr(rd_ptr);
                fill--;
            end
            loop_mem[wr_ptr] = sum[SAMPLE_W-1:0];
            wr_ptr = next_ptr(wr_ptr);
            fill++;
            return;
        end
        mic = mute_reg ? 0 : int'($signed(bt.a));
        res.added = 1'b0;
        if (mix_en_reg && fill > 0)
        begin
            mic += int'($signed(loop_mem[rd_ptr]));
            if (mic < int'(SAMPLE_MIN))
                mic = int'(SAMPLE_MIN);
            if (mic > int'(SAMPLE_MAX))
                mic = int'(SAMPLE_MAX);
            res.added = 1'b1;
            if (bt.last)
            begin
                rd_ptr = next_ptr(rd_ptr);
                fill--;
            end
        end
        res.mixed = mic[SAMPLE_W-1:0];
        res.bend  = bt.bend;
        expected_mix_q.insert(expected_mix_q.size(), res);
    endfunction

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return -16'sd1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic void add_beat(input logic f, input logic signed [SAMPLE_W-1:0] a,
                                     input logic signed [SAMPLE_W-1:0] b, input logic st,
                                     input logic lc, input logic be);
        audio_beat_t bt;
        bt.func   = f;
        bt.a      = a;
        bt.b      = b;
        bt.stereo = st;
        bt.last   = lc;
        bt.bend   = be;
        beat_q.insert(beat_q.size(), bt);
    endfunction

    // input driver
    always @(posedge clk)
    begin
        audio_beat_t nb;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                predict_mix_result(cur_beat);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (beat_q.size() != 0)
                begin
                    nb = beat_q.pop_front();
                    cur_beat     = nb;
                    func         <= nb.func;
                    sample_a     <= nb.a;
                    sample_b     <= nb.b;
                    stereo       <= nb.stereo;
                    last_channel <= nb.last;
                    block_end    <= nb.bend;
                    in_valid     <= 1'b1;
                    send_gap     = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output stall, with an occasional long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_req_cnt != hold_ack_cnt)
        begin
            hold_ack_cnt = hold_req_cnt;
            hold_left    = LONG_HOLD_CYCLES - 1;
            out_stall    <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            out_stall  <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        mix_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_mix_q.size() == 0)
            begin
                $error("result beat with nothing expected: mixed_sample %0d", mixed_sample);
                err_count++;
            end
            else
            begin
                exp_res = expected_mix_q.pop_front();
                if (mixed_sample !== exp_res.mixed)
                begin
                    $error("mixed_sample: expected %0d, got %0d", exp_res.mixed, mixed_sample);
                    err_count++;
                end
                if (loopback_added !== exp_res.added)
                begin
                    $error("loopback_added: expected %0d, got %0d", exp_res.added,
                           loopback_added);
                    err_count++;
                end
                if (block_end_out !== exp_res.bend)
                begin
                    $error("block_end_out: expected %0d, got %0d", exp_res.bend,
                           block_end_out);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("loopback_audio_fifo_mixer_top_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (beat_q.size() != 0 || in_valid || expected_mix_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MIX_ENABLE)
            mix_en_reg = val;
        else if (idx == CFG_MIC_MUTE)
            mute_reg = val;
        @(negedge clk);
    endtask

    // mostly pushes and well-formed mic frames, some fully random beats
    task automatic send_random_traffic(input int n);
        int sent;
        int chans;
        int r;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
            begin
                add_beat(FUNC_PUSH, pick_sample(), pick_sample(), 1'($urandom),
                         1'($urandom), 1'($urandom));
                sent++;
            end
            else if (r < 9)
            begin
                chans = $urandom_range(1, 2);
                for (int c = 0; c < chans; c++)
                    add_beat(FUNC_MIX, pick_sample(), pick_sample(), 1'($urandom),
                             (c == chans - 1), ($urandom_range(0, 7) == 0));
                sent += chans;
            end
            else
            begin
                add_beat(1'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                         1'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end
            @(negedge clk);
        end
    endtask

    task automatic run_phase(input logic en, input logic mute, input logic no_gaps,
                             input logic long_hold, input int n);
        wait_drained();
        write_reg(CFG_MIX_ENABLE, en);
        write_reg(CFG_MIC_MUTE, mute);
        quiet = no_gaps;
        if (long_hold)
            hold_req_cnt++;
        send_random_traffic(n);
        wait_drained();
        quiet = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < BUFFER_DEPTH; i++)
            loop_mem[i] = '0;
        rd_ptr     = 0;
        wr_ptr     = 0;
        fill       = 0;
        mix_en_reg = 1'b0;
        mute_reg   = 1'b0;
        err_count  = 0;
        send_gap   = 0;
        stall_left = 0;
        hold_left  = 0;
        hold_req_cnt = 0;
        hold_ack_cnt = 0;
        idle_cycles  = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // mixing off after reset: mic passes, pushes only fill the fifo
        add_beat(FUNC_MIX, SAMPLE_MAX, '0, 1'b0, 1'b1, 1'b1);
        add_beat(FUNC_MIX, SAMPLE_MIN, SAMPLE_MAX, 1'b1, 1'b0, 1'b0);
        add_beat(FUNC_PUSH, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 1'b1, 1'b1);
        add_beat(FUNC_MIX, 16'sd5, '0, 1'b0, 1'b1, 1'b0);
        add_beat(FUNC_PUSH, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b0, 1'b0);
        add_beat(FUNC_PUSH, SAMPLE_MIN, SAMPLE_MIN, 1'b1, 1'b0, 1'b0);
        add_beat(FUNC_PUSH, -16'sd3, '0, 1'b1, 1'b0, 1'b0);
        add_beat(FUNC_PUSH, 16'sd3, '0, 1'b1, 1'b0, 1'b0);
        add_beat(FUNC_PUSH, SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b0, 1'b0);
        wait_drained();
        write_reg(CFG_MIX_ENABLE, 1'b1);

        // saturation both ways, hold without last channel, then empty fifo
        add_beat(FUNC_MIX, SAMPLE_MAX, '0, 1'b0, 1'b0, 1'b0);
        add_beat(FUNC_MIX, 16'sd1, '0, 1'b0, 1'b1, 1'b1);
        add_beat(FUNC_MIX, SAMPLE_MIN, '0, 1'b0, 1'b1, 1'b0);
        add_beat(FUNC_MIX, SAMPLE_MIN, '0, 1'b0, 1'b1, 1'b0);
        add_beat(FUNC_MIX, '0, '0, 1'b0, 1'b1, 1'b0);
        add_beat(FUNC_MIX, '0, '0, 1'b0, 1'b1, 1'b0);
        add_beat(FUNC_MIX, 16'sd7, '0, 1'b0, 1'b1, 1'b0);
        add_beat(FUNC_MIX, -16'sd9, '0, 1'b0, 1'b1, 1'b1);
        wait_drained();
        write_reg(CFG_MIC_MUTE, 1'b1);
        write_reg(CFG_SPARE_A, 1'b0);
        write_reg(CFG_SPARE_B, 1'b1);
        add_beat(FUNC_PUSH, 16'sd1234, '0, 1'b0, 1'b0, 1'b0);
        add_beat(FUNC_MIX, SAMPLE_MAX, '0, 1'b0, 1'b1, 1'b0);
        add_beat(FUNC_MIX, SAMPLE_MIN, '0, 1'b0, 1'b1, 1'b1);
        wait_drained();
        write_reg(CFG_SPARE_A, 1'b1);
        write_reg(CFG_SPARE_B, 1'b0);

        run_phase(1'b1, 1'b0, 1'b0, 1'b0, 160);
        run_phase(1'b1, 1'b0, 1'b1, 1'b0, 120);
        run_phase(1'b1, 1'b1, 1'b0, 1'b1, 160);
        run_phase(1'b0, 1'b1, 1'b0, 1'b0, 110);
        run_phase(1'b0, 1'b0, 1'b0, 1'b0, 110);
        run_phase(1'b1, 1'b0, 1'b0, 1'b0, 140);
        run_phase(1'b1, 1'b0, 1'b0, 1'b0, 60);

        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("loopback_audio_fifo_mixer_top_tb OK");
        else
            $display("loopback_audio_fifo_mixer_top_tb NOT OK");
        $finish;
    end

endmodule
